### design/dsgpg_pkg.sv
package dsgpg_pkg;

   localparam int CMD_W     = 2;
   localparam int ID_W      = 1;
   localparam int POS_W     = 12;
   localparam int SPEED_W   = 10;
   localparam int BYTE_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;

   localparam int COEF_W = 15;
   localparam int PROD_W = 28;
   localparam int SUM_W  = 29;
   localparam int MAG_W  = 28;
   localparam int T_W    = MAG_W - POS_W;
   localparam int Y_W    = T_W + 1;
   localparam int T2_W   = Y_W - POS_W;
   localparam int Q_W    = T_W + 1;
   localparam int P_W    = Q_W + 2;
   localparam int CNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_GOAL  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ANGLE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SPEED = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESV  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_HOME0 = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOME1 = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED = 2'd2;

   localparam logic [POS_W-1:0]   HOME_RESET  = 12'd512;
   localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd20;

   localparam logic [BYTE_W-1:0] HDR_BYTE    = 8'hFF;
   localparam logic [BYTE_W-1:0] LEN_BYTE    = 8'h05;
   localparam logic [BYTE_W-1:0] INSTR_WRITE = 8'h03;
   localparam logic [BYTE_W-1:0] ADDR_GOAL   = 8'h1E;
   localparam logic [BYTE_W-1:0] ADDR_SPEED  = 8'h20;

   localparam logic [CNT_W-1:0] PKT_LEN     = 5'd9;
   localparam logic [CNT_W-1:0] LAST_SINGLE = 5'd8;
   localparam logic [CNT_W-1:0] LAST_PAIR   = 5'd17;

   localparam logic signed [COEF_W-1:0] K_POS_MAX  = 15'sd4095;
   localparam logic signed [COEF_W-1:0] K_POS_MAX2 = 15'sd8190;
   localparam logic [POS_W:0]           K_DIV      = 13'd4095;

   typedef enum logic [1:0] {
      JOB_SINGLE = 2'd0,
      JOB_PAIR   = 2'd1,
      JOB_ERROR  = 2'd2
   } dsgpg_kind_type;

   typedef struct packed {
      dsgpg_kind_type     kind;
      logic [ID_W-1:0]    id;
      logic [BYTE_W-1:0]  addr;
      logic [POS_W-1:0]   val0;
      logic [POS_W-1:0]   val1;
   } dsgpg_job_type;

   // signed halving, truncated toward zero
   function automatic logic signed [COEF_W-1:0] half_tq(input logic signed [COEF_W-1:0] v);
      logic signed [COEF_W-1:0] adj;
      adj = v + $signed({{(COEF_W-1){1'b0}}, v[COEF_W-1]});
      return adj >>> 1;
   endfunction

   function automatic logic [BYTE_W-1:0] pkt_chk(input logic [ID_W-1:0] id,
                                                 input logic [BYTE_W-1:0] addr,
                                                 input logic [POS_W-1:0] val);
      logic [BYTE_W-1:0] sum;
      sum = {{(BYTE_W-ID_W){1'b0}}, id} + LEN_BYTE + INSTR_WRITE + addr + val[7:0]
            + {{(2*BYTE_W-POS_W){1'b0}}, val[POS_W-1:BYTE_W]};
      return ~sum;
   endfunction

endpackage

### design/dsgpg_if.sv
interface dsgpg_req_if import dsgpg_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [ID_W-1:0]    motor_id;
   logic [POS_W-1:0]   target_position;
   logic [POS_W-1:0]   rotate_slider;
   logic [POS_W-1:0]   pitch_slider;

   modport source (output valid, command, motor_id, target_position, rotate_slider,
                   pitch_slider, input ready);
   modport sink (input valid, command, motor_id, target_position, rotate_slider,
                 pitch_slider, output ready);
endinterface

interface dsgpg_rsp_if import dsgpg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] tx_byte;
   logic              byte_valid;
   logic              last_of_run;
   logic              range_error;

   modport source (output valid, tx_byte, byte_valid, last_of_run, range_error,
                   input ready);
   modport sink (input valid, tx_byte, byte_valid, last_of_run, range_error,
                 output ready);
endinterface

interface dsgpg_csr_if import dsgpg_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### design/dsgpg_mix.sv
module dsgpg_mix import dsgpg_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   dsgpg_req_if.sink          req_bus,
   input  logic [POS_W-1:0]   home0,
   input  logic [POS_W-1:0]   home1,
   input  logic [SPEED_W-1:0] speed,
   output logic               job_valid,
   output dsgpg_job_type      job,
   input  logic               job_ready
);

   logic adv;

   // mixing coefficients from the home registers
   logic signed [COEF_W-1:0] h0s, h1s, ca, cb, cc, cd;
   logic signed [COEF_W-1:0] ab_in, cdd_in, bpd_in, bmd_in;
   logic signed [COEF_W-1:0] ab_ff, cdd_ff, bpd_ff, bmd_ff;

   // stage 1: input register
   logic               s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]   s1_cmd_ff;
   logic [ID_W-1:0]    s1_id_ff;
   logic [POS_W-1:0]   s1_tgt_ff, s1_rot_ff, s1_pit_ff;

   // stage 2: products
   logic               s2_valid_ff;
   logic [CMD_W-1:0]   s2_cmd_ff;
   logic [ID_W-1:0]    s2_id_ff;
   logic [POS_W-1:0]   s2_tgt_ff;
   logic signed [PROD_W-1:0] rot_x, pit_x, ab_x, cdd_x, bpd_x, bmd_x;
   logic signed [PROD_W-1:0] ps_in, pp_in, k0_in, k1_in;
   logic signed [PROD_W-1:0] ps_ff, pp_ff, k0_ff, k1_ff;

   // stage 3: numerators
   logic               s3_valid_ff;
   logic [CMD_W-1:0]   s3_cmd_ff;
   logic [ID_W-1:0]    s3_id_ff;
   logic [POS_W-1:0]   s3_tgt_ff;
   logic signed [SUM_W-1:0] n0_in, n1_in, n0_ff, n1_ff;

   // stage 4: magnitude and first fold of the divide by 4095
   logic               s4_valid_ff;
   logic [CMD_W-1:0]   s4_cmd_ff;
   logic [ID_W-1:0]    s4_id_ff;
   logic [POS_W-1:0]   s4_tgt_ff;
   logic signed [SUM_W-1:0] a0, a1;
   logic [MAG_W-1:0]   mag0, mag1;
   logic               neg0_in, neg1_in, neg0_ff, neg1_ff;
   logic [T_W-1:0]     t0_in, t1_in, t0_ff, t1_ff;
   logic [Y_W-1:0]     y0_in, y1_in, y0_ff, y1_ff;

   // stage 5: quotient, position, packet job
   logic               s5_valid_ff;
   dsgpg_job_type      job_in, job_ff;
   logic [T2_W-1:0]    u0, u1;
   logic [POS_W:0]     z0, z1;
   logic               c0, c1;
   logic [Q_W-1:0]     q0, q1;
   logic signed [P_W-1:0] hq0, hq1, qq0, qq1, pos0, pos1;
   logic               ok0, ok1;

   assign adv           = !s5_valid_ff || job_ready;
   assign req_bus.ready = adv;
   assign job_valid     = s5_valid_ff;
   assign job           = job_ff;

   always_comb begin
      h0s    = $signed({{(COEF_W-POS_W){1'b0}}, home0});
      h1s    = $signed({{(COEF_W-POS_W){1'b0}}, home1});
      ca     = half_tq(K_POS_MAX2 - h0s - h1s);
      cb     = half_tq(-h0s - h1s);
      cc     = half_tq(K_POS_MAX - h0s + h1s);
      cd     = half_tq(h1s - h0s - K_POS_MAX);
      ab_in  = ca - cb;
      cdd_in = cc - cd;
      bpd_in = cb + cd;
      bmd_in = cb - cd;
   end

   always_ff @(posedge clock) begin
      ab_ff  <= ab_in;
      cdd_ff <= cdd_in;
      bpd_ff <= bpd_in;
      bmd_ff <= bmd_in;
   end

   assign s1_valid_in = req_bus.valid && (req_bus.command != CMD_RESV);

   always_comb begin
      rot_x = $signed({{(PROD_W-POS_W){1'b0}}, s1_rot_ff});
      pit_x = $signed({{(PROD_W-POS_W){1'b0}}, s1_pit_ff});
      ab_x  = {{(PROD_W-COEF_W){ab_ff[COEF_W-1]}}, ab_ff};
      cdd_x = {{(PROD_W-COEF_W){cdd_ff[COEF_W-1]}}, cdd_ff};
      bpd_x = {{(PROD_W-COEF_W){bpd_ff[COEF_W-1]}}, bpd_ff};
      bmd_x = {{(PROD_W-COEF_W){bmd_ff[COEF_W-1]}}, bmd_ff};
      ps_in = rot_x * ab_x;
      pp_in = pit_x * cdd_x;
      k0_in = (bpd_x <<< POS_W) - bpd_x;
      k1_in = (bmd_x <<< POS_W) - bmd_x;
   end

   always_comb begin
      n0_in = {ps_ff[PROD_W-1], ps_ff} + {pp_ff[PROD_W-1], pp_ff} + {k0_ff[PROD_W-1], k0_ff};
      n1_in = {ps_ff[PROD_W-1], ps_ff} - {pp_ff[PROD_W-1], pp_ff} + {k1_ff[PROD_W-1], k1_ff};
   end

   always_comb begin
      neg0_in = n0_ff[SUM_W-1];
      neg1_in = n1_ff[SUM_W-1];
      a0      = neg0_in ? -n0_ff : n0_ff;
      a1      = neg1_in ? -n1_ff : n1_ff;
      mag0    = a0[MAG_W-1:0];
      mag1    = a1[MAG_W-1:0];
      t0_in   = mag0[MAG_W-1:POS_W];
      t1_in   = mag1[MAG_W-1:POS_W];
      y0_in   = {1'b0, t0_in} + {{(Y_W-POS_W){1'b0}}, mag0[POS_W-1:0]};
      y1_in   = {1'b0, t1_in} + {{(Y_W-POS_W){1'b0}}, mag1[POS_W-1:0]};
   end

   always_comb begin
      u0   = y0_ff[Y_W-1:POS_W];
      u1   = y1_ff[Y_W-1:POS_W];
      z0   = {{(POS_W+1-T2_W){1'b0}}, u0} + {1'b0, y0_ff[POS_W-1:0]};
      z1   = {{(POS_W+1-T2_W){1'b0}}, u1} + {1'b0, y1_ff[POS_W-1:0]};
      c0   = (z0 >= K_DIV);
      c1   = (z1 >= K_DIV);
      q0   = {1'b0, t0_ff} + {{(Q_W-T2_W){1'b0}}, u0} + {{(Q_W-1){1'b0}}, c0};
      q1   = {1'b0, t1_ff} + {{(Q_W-T2_W){1'b0}}, u1} + {{(Q_W-1){1'b0}}, c1};
      hq0  = $signed({{(P_W-POS_W){1'b0}}, home0});
      hq1  = $signed({{(P_W-POS_W){1'b0}}, home1});
      qq0  = $signed({2'b00, q0});
      qq1  = $signed({2'b00, q1});
      pos0 = neg0_ff ? hq0 - qq0 : hq0 + qq0;
      pos1 = neg1_ff ? hq1 - qq1 : hq1 + qq1;
      ok0  = (pos0[P_W-1:POS_W] == '0);
      ok1  = (pos1[P_W-1:POS_W] == '0);

      job_in.kind = JOB_ERROR;
      job_in.id   = '0;
      job_in.addr = ADDR_GOAL;
      job_in.val0 = s4_tgt_ff;
      job_in.val1 = s4_tgt_ff;
      case (s4_cmd_ff)
         CMD_GOAL: begin
            job_in.kind = JOB_SINGLE;
            job_in.id   = s4_id_ff;
         end
         CMD_ANGLE: begin
            job_in.kind = (ok0 && ok1) ? JOB_PAIR : JOB_ERROR;
            job_in.val0 = pos0[POS_W-1:0];
            job_in.val1 = pos1[POS_W-1:0];
         end
         CMD_SPEED: begin
            job_in.kind = JOB_PAIR;
            job_in.addr = ADDR_SPEED;
            job_in.val0 = {{(POS_W-SPEED_W){1'b0}}, speed};
            job_in.val1 = {{(POS_W-SPEED_W){1'b0}}, speed};
         end
         default: begin
            job_in.kind = JOB_ERROR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff <= req_bus.command;
         s1_id_ff  <= req_bus.motor_id;
         s1_tgt_ff <= req_bus.target_position;
         s1_rot_ff <= req_bus.rotate_slider;
         s1_pit_ff <= req_bus.pitch_slider;

         s2_cmd_ff <= s1_cmd_ff;
         s2_id_ff  <= s1_id_ff;
         s2_tgt_ff <= s1_tgt_ff;
         ps_ff     <= ps_in;
         pp_ff     <= pp_in;
         k0_ff     <= k0_in;
         k1_ff     <= k1_in;

         s3_cmd_ff <= s2_cmd_ff;
         s3_id_ff  <= s2_id_ff;
         s3_tgt_ff <= s2_tgt_ff;
         n0_ff     <= n0_in;
         n1_ff     <= n1_in;

         s4_cmd_ff <= s3_cmd_ff;
         s4_id_ff  <= s3_id_ff;
         s4_tgt_ff <= s3_tgt_ff;
         neg0_ff   <= neg0_in;
         neg1_ff   <= neg1_in;
         t0_ff     <= t0_in;
         t1_ff     <= t1_in;
         y0_ff     <= y0_in;
         y1_ff     <= y1_in;

         job_ff    <= job_in;
      end
   end

endmodule

### design/dsgpg_pktgen.sv
module dsgpg_pktgen import dsgpg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          job_valid,
   input  dsgpg_job_type job,
   output logic          job_ready,
   dsgpg_rsp_if.source   rsp_bus
);

   logic                busy_ff, busy_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   dsgpg_job_type       cur_ff, cur_in;
   logic [BYTE_W-1:0]   chk0_ff, chk0_in, chk1_ff, chk1_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   tx_ff, tx_in;
   logic                bv_ff, bv_in;
   logic                last_ff, last_in;
   logic                err_ff, err_in;

   logic                out_free, load, second, last_beat;
   logic [CNT_W-1:0]    diff;
   logic [3:0]          bpos;
   logic [ID_W-1:0]     pid;
   logic [POS_W-1:0]    val;
   logic [BYTE_W-1:0]   chk, pkt_byte;

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign job_ready = !busy_ff || (out_free && last_beat);
   assign load      = job_valid && job_ready;

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.tx_byte     = tx_ff;
   assign rsp_bus.byte_valid  = bv_ff;
   assign rsp_bus.last_of_run = last_ff;
   assign rsp_bus.range_error = err_ff;

   always_comb begin
      second = (cnt_ff >= PKT_LEN);
      diff   = cnt_ff - PKT_LEN;
      bpos   = second ? diff[3:0] : cnt_ff[3:0];
      pid    = second ? {{(ID_W-1){1'b0}}, 1'b1} : cur_ff.id;
      val    = second ? cur_ff.val1 : cur_ff.val0;
      chk    = second ? chk1_ff : chk0_ff;

      case (bpos)
         4'd0, 4'd1: pkt_byte = HDR_BYTE;
         4'd2:       pkt_byte = {{(BYTE_W-ID_W){1'b0}}, pid};
         4'd3:       pkt_byte = LEN_BYTE;
         4'd4:       pkt_byte = INSTR_WRITE;
         4'd5:       pkt_byte = cur_ff.addr;
         4'd6:       pkt_byte = val[BYTE_W-1:0];
         4'd7:       pkt_byte = {{(2*BYTE_W-POS_W){1'b0}}, val[POS_W-1:BYTE_W]};
         4'd8:       pkt_byte = chk;
         default:    pkt_byte = '0;
      endcase

      case (cur_ff.kind)
         JOB_SINGLE: last_beat = (cnt_ff == LAST_SINGLE);
         JOB_PAIR:   last_beat = (cnt_ff == LAST_PAIR);
         default:    last_beat = 1'b1;
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      chk0_in      = chk0_ff;
      chk1_in      = chk1_ff;
      rsp_valid_in = rsp_valid_ff;
      tx_in        = tx_ff;
      bv_in        = bv_ff;
      last_in      = last_ff;
      err_in       = err_ff;

      if (out_free) begin
         rsp_valid_in = busy_ff;
         if (cur_ff.kind == JOB_ERROR) begin
            tx_in   = '0;
            bv_in   = 1'b0;
            err_in  = 1'b1;
         end else begin
            tx_in   = pkt_byte;
            bv_in   = 1'b1;
            err_in  = 1'b0;
         end
         last_in = last_beat;
         if (busy_ff) begin
            cnt_in = cnt_ff + 1'b1;
            if (last_beat) begin
               busy_in = 1'b0;
            end
         end
      end

      if (load) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         cur_in  = job;
         chk0_in = pkt_chk(job.id, job.addr, job.val0);
         chk1_in = pkt_chk({{(ID_W-1){1'b0}}, 1'b1}, job.addr, job.val1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         cur_ff       <= '{kind: JOB_ERROR, id: '0, addr: '0, val0: '0, val1: '0};
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      chk0_ff     <= chk0_in;
      chk1_ff     <= chk1_in;
      tx_ff       <= tx_in;
      bv_ff       <= bv_in;
      last_ff     <= last_in;
      err_ff      <= err_in;
   end

endmodule

### design/dual_servo_gimbal_packet_gen.sv
// channel   dir  beat
// req_bus   in   command, motor_id, target_position, rotate_slider, pitch_slider
// rsp_bus   out  tx_byte, byte_valid, last_of_run, range_error
// csr_bus   in   index, data (0 home_motor0, 1 home_motor1, 2 servo speed)
//
// five register stages mix the sliders, then a byte serializer sends one beat a cycle
// while rsp_ready is high: 9 beats for a goal position, 18 for angle drive or speed,
// 1 for a range error. first beat passes the mix stages and the serializer registers.
// reset empties the pipeline and loads homes 512/512 and speed 20.
// rsp_ready low holds the output beat and backs up the stages to req_bus.ready.
module dual_servo_gimbal_packet_gen import dsgpg_pkg::*; (
   input logic         clock,
   input logic         reset,
   dsgpg_req_if.sink   req_bus,
   dsgpg_rsp_if.source rsp_bus,
   dsgpg_csr_if.sink   csr_bus
);

   logic [POS_W-1:0]   home0_ff, home0_in, home1_ff, home1_in;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic               job_valid, job_ready;
   dsgpg_job_type      job;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      home0_in = home0_ff;
      home1_in = home1_ff;
      speed_in = speed_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_HOME0: home0_in = csr_bus.data[POS_W-1:0];
            REG_HOME1: home1_in = csr_bus.data[POS_W-1:0];
            REG_SPEED: speed_in = csr_bus.data[SPEED_W-1:0];
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home0_ff <= HOME_RESET;
         home1_ff <= HOME_RESET;
         speed_ff <= SPEED_RESET;
      end else begin
         home0_ff <= home0_in;
         home1_ff <= home1_in;
         speed_ff <= speed_in;
      end
   end

   dsgpg_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .home0     (home0_ff),
      .home1     (home1_ff),
      .speed     (speed_ff),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready)
   );

   dsgpg_pktgen u_pktgen (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_ready (job_ready),
      .rsp_bus   (rsp_bus)
   );

endmodule
